[hw/rtl/pchg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Height grid package
// Shared constants, codes, command and status types of the height grid block.
// ----------------------------------------------------------------------------
package pchg_pkg;

    // Fixed point format and arithmetic widths.
    localparam int FRAC_BITS = 16;
    localparam int OPW       = 33;           // multiplier operand width
    localparam int PRW       = 2 * OPW;      // full product width
    localparam int ACCW      = 52;           // row accumulator width
    localparam int BINW      = 34;           // truncated bin or shift count

    // Grid size defaults.
    localparam int CELLS_X_DEF = 300;
    localparam int CELLS_Y_DEF = 200;

    // Coefficient store layout.
    localparam int          NUM_COEF = 24;
    localparam logic [4:0]  BASE_M   = 5'd0;
    localparam logic [4:0]  BASE_O   = 5'd9;
    localparam logic [4:0]  BASE_B   = 5'd12;
    localparam logic [4:0]  BASE_P   = 5'd21;
    localparam logic [4:0]  POSE_X   = 5'd21;
    localparam logic [4:0]  POSE_Y   = 5'd22;

    // Configuration registers.
    localparam int          CFG_W       = 31;
    localparam logic [1:0]  CFG_INV     = 2'd0;
    localparam logic [1:0]  CFG_HALF_X  = 2'd1;
    localparam logic [1:0]  CFG_HALF_Y  = 2'd2;
    localparam logic [CFG_W-1:0] INV_RST    = 31'd13107200;
    localparam logic [CFG_W-1:0] HALF_X_RST = 31'd49152;
    localparam logic [CFG_W-1:0] HALF_Y_RST = 31'd32768;

    // Word layout.
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 56;
    localparam int ROW_W      = 9;
    localparam int COL_W      = 8;
    localparam int SX_W       = 10;
    localparam int SY_W       = 9;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_FRAME  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        TK_NONE,
        TK_FIRST,
        TK_MID,
        TK_LAST,
        TK_BINX,
        TK_BINY,
        TK_FEX,
        TK_FEY
    } tag_kind_t;

    typedef struct packed {
        tag_kind_t  kind;
        logic [1:0] idx;
    } tag_t;

    typedef enum logic [2:0] {
        MS_ROT,
        MS_BINX,
        MS_BINY,
        MS_FEX,
        MS_FEY
    } mul_sel_t;

    typedef enum logic [1:0] {
        SW_CLEAR,
        SW_X,
        SW_Y
    } sw_mode_t;

    typedef enum logic [4:0] {
        ST_SW_INIT,
        ST_SW_PREP,
        ST_SW_RUN,
        ST_SW_DRAIN,
        ST_IDLE,
        ST_LOAD,
        ST_ROT,
        ST_SUB,
        ST_BIN,
        ST_IADDR,
        ST_IWRITE,
        ST_FE_MUL,
        ST_FE_POSE_X,
        ST_FE_POSE_Y,
        ST_RD_ADDR,
        ST_RD_MEM,
        ST_RD_DATA,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       cap;
        logic       coef_we;
        mul_sel_t   mul_sel;
        logic [4:0] cidx;
        logic [1:0] vsel;
        tag_t       tag;
        logic       sub_en;
        logic [1:0] sub_idx;
        logic       bin_addr;
        logic       ins_we;
        logic       rd_addr;
        logic       rd_en;
        logic       rd_take;
        logic       pose_x;
        logic       pose_y;
        logic       sw_init;
        sw_mode_t   sw_mode;
        logic       sw_prep;
        logic       sw_step;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic dx_nz;
        logic dy_nz;
        logic sw_last;
    } ctrl_status_t;

endpackage

[hw/rtl/point_cloud_height_grid_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point cloud height grid
// Transforms camera points into a robot-centred grid of cell heights.
// ----------------------------------------------------------------------------
// Throughput: one word at a time, the next taken the cycle after the result loads;
// the shared 33x33 multiplier (two rotations of nine products each) sets the insert
// time, the single grid memory port pair sets the shift time of one cell per cycle.
// Reset: after rst_n rises the grid is cleared in a sweep, during which no word
// is taken; configuration writes are taken.
module point_cloud_height_grid_top #(
    parameter int CELLS_X = pchg_pkg::CELLS_X_DEF,
    parameter int CELLS_Y = pchg_pkg::CELLS_Y_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input words.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // coeff_index[4:0], coeff_value[36:5], point_x[68:37], point_y[100:69],
    // point_z[132:101], read_row[141:133], read_col[149:142], zero pad.
    input  logic [pchg_pkg::IN_DATA_W-1:0]    s_tdata,
    // command[1:0]
    input  logic [1:0]                        s_tuser,
    // Result words.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // cell_height[31:0], point_dropped[32], shift_x_cells[42:33],
    // shift_y_cells[51:43], zero pad.
    output logic [pchg_pkg::OUT_DATA_W-1:0]   m_tdata,
    // Configuration writes.
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [pchg_pkg::CFG_W-1:0]        cfg_data
);

    // The controller and the datapath talk only through these two bundles.
    pchg_pkg::ctrl_cmd_t    cmd;
    pchg_pkg::ctrl_status_t status;

    // The controller decides the order of work: the clearing sweep after
    // reset, the rotation steps of an insert, and the per-axis grid moves.
    pchg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds every value: coefficients, the multiplier pipe,
    // the grid memory and the result register, which keeps a finished
    // word while the next input is already taken.
    pchg_datapath #(
        .CELLS_X (CELLS_X),
        .CELLS_Y (CELLS_Y)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[hw/rtl/pchg_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module pchg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/pchg_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Height grid controller
// Sequences each command through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module pchg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  pchg_pkg::ctrl_status_t status,
    output pchg_pkg::ctrl_cmd_t    cmd
);

    pchg_pkg::state_t   state_reg, state_next;
    pchg_pkg::sw_mode_t phase_reg, phase_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [1:0]         i_reg, i_next;
    logic [1:0]         j_reg, j_next;
    logic               pass_reg, pass_next;
    logic               m_valid_reg, m_valid_next;

    // Dispatch register: set on acceptance, routes on the captured command.
    logic               dispatch_reg;
    pchg_pkg::state_t   state_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pchg_pkg::ST_SW_INIT;
            phase_reg   <= pchg_pkg::SW_CLEAR;
            cnt_reg     <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            pass_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            pass_reg    <= pass_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_eff;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        pass_next    = pass_reg;
        m_valid_next = m_valid_reg && !m_tready;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.mul_sel  = pchg_pkg::MS_ROT;
        cmd.tag.kind = pchg_pkg::TK_NONE;
        cmd.sw_mode  = phase_reg;

        case (state_eff)
            pchg_pkg::ST_SW_INIT:
            begin
                cmd.sw_init = 1'b1;
                state_next  = pchg_pkg::ST_SW_PREP;
            end
            pchg_pkg::ST_SW_PREP:
            begin
                cmd.sw_prep = 1'b1;
                state_next  = pchg_pkg::ST_SW_RUN;
            end
            pchg_pkg::ST_SW_RUN:
            begin
                cmd.sw_step = 1'b1;
                if (status.sw_last)
                begin
                    state_next = pchg_pkg::ST_SW_DRAIN;
                end
            end
            pchg_pkg::ST_SW_DRAIN:
            begin
                case (phase_reg)
                    pchg_pkg::SW_CLEAR: state_next = pchg_pkg::ST_IDLE;
                    pchg_pkg::SW_X:
                    begin
                        if (status.dy_nz)
                        begin
                            phase_next = pchg_pkg::SW_Y;
                            state_next = pchg_pkg::ST_SW_INIT;
                        end
                        else
                        begin
                            state_next = pchg_pkg::ST_OUT;
                        end
                    end
                    default: state_next = pchg_pkg::ST_OUT;
                endcase
            end
            pchg_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.cap  = 1'b1;
                    cnt_next = '0;
                    i_next   = '0;
                    j_next   = '0;
                    pass_next = 1'b0;
                    state_next = pchg_pkg::ST_OUT;
                end
            end
            pchg_pkg::ST_LOAD:
            begin
                cmd.coef_we = 1'b1;
                state_next  = pchg_pkg::ST_OUT;
            end
            pchg_pkg::ST_ROT:
            begin
                cmd.mul_sel = pchg_pkg::MS_ROT;
                cmd.cidx    = (pass_reg ? pchg_pkg::BASE_B : pchg_pkg::BASE_M) + 5'(cnt_reg);
                cmd.vsel    = j_reg;
                cmd.tag.idx = i_reg;
                cnt_next    = cnt_reg + 4'd1;
                if (cnt_reg < 4'd9)
                begin
                    if (j_reg == 2'd0)
                    begin
                        cmd.tag.kind = pchg_pkg::TK_FIRST;
                    end
                    else if (j_reg == 2'd2)
                    begin
                        cmd.tag.kind = pchg_pkg::TK_LAST;
                    end
                    else
                    begin
                        cmd.tag.kind = pchg_pkg::TK_MID;
                    end
                    if (j_reg == 2'd2)
                    begin
                        j_next = '0;
                        i_next = i_reg + 2'd1;
                    end
                    else
                    begin
                        j_next = j_reg + 2'd1;
                    end
                end
                // Wait while the last row passes the operand and product registers into its result register.
                if (cnt_reg == 4'd10)
                begin
                    cnt_next   = '0;
                    state_next = pchg_pkg::ST_SUB;
                end
            end
            pchg_pkg::ST_SUB:
            begin
                cmd.sub_en  = 1'b1;
                cmd.sub_idx = cnt_reg[1:0];
                cmd.cidx    = (pass_reg ? pchg_pkg::BASE_P : pchg_pkg::BASE_O) + 5'(cnt_reg);
                cnt_next    = cnt_reg + 4'd1;
                if (cnt_reg == 4'd2)
                begin
                    cnt_next = '0;
                    i_next   = '0;
                    j_next   = '0;
                    if (pass_reg)
                    begin
                        state_next = pchg_pkg::ST_BIN;
                    end
                    else
                    begin
                        pass_next  = 1'b1;
                        state_next = pchg_pkg::ST_ROT;
                    end
                end
            end
            pchg_pkg::ST_BIN:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    cmd.mul_sel  = pchg_pkg::MS_BINX;
                    cmd.tag.kind = pchg_pkg::TK_BINX;
                end
                else if (cnt_reg == 4'd1)
                begin
                    cmd.mul_sel  = pchg_pkg::MS_BINY;
                    cmd.tag.kind = pchg_pkg::TK_BINY;
                end
                if (cnt_reg == 4'd3)
                begin
                    cnt_next   = '0;
                    state_next = pchg_pkg::ST_IADDR;
                end
            end
            pchg_pkg::ST_IADDR:
            begin
                cmd.bin_addr = 1'b1;
                state_next   = pchg_pkg::ST_IWRITE;
            end
            pchg_pkg::ST_IWRITE:
            begin
                cmd.ins_we = 1'b1;
                state_next = pchg_pkg::ST_OUT;
            end
            pchg_pkg::ST_FE_MUL:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    cmd.mul_sel  = pchg_pkg::MS_FEX;
                    cmd.cidx     = pchg_pkg::POSE_X;
                    cmd.tag.kind = pchg_pkg::TK_FEX;
                end
                else if (cnt_reg == 4'd1)
                begin
                    cmd.mul_sel  = pchg_pkg::MS_FEY;
                    cmd.cidx     = pchg_pkg::POSE_Y;
                    cmd.tag.kind = pchg_pkg::TK_FEY;
                end
                if (cnt_reg == 4'd3)
                begin
                    cnt_next   = '0;
                    state_next = pchg_pkg::ST_FE_POSE_X;
                end
            end
            pchg_pkg::ST_FE_POSE_X:
            begin
                cmd.pose_x = 1'b1;
                cmd.cidx   = pchg_pkg::POSE_X;
                state_next = pchg_pkg::ST_FE_POSE_Y;
            end
            pchg_pkg::ST_FE_POSE_Y:
            begin
                cmd.pose_y = 1'b1;
                cmd.cidx   = pchg_pkg::POSE_Y;
                if (status.dx_nz)
                begin
                    phase_next = pchg_pkg::SW_X;
                    state_next = pchg_pkg::ST_SW_INIT;
                end
                else if (status.dy_nz)
                begin
                    phase_next = pchg_pkg::SW_Y;
                    state_next = pchg_pkg::ST_SW_INIT;
                end
                else
                begin
                    state_next = pchg_pkg::ST_OUT;
                end
            end
            pchg_pkg::ST_RD_ADDR:
            begin
                cmd.rd_addr = 1'b1;
                state_next  = pchg_pkg::ST_RD_MEM;
            end
            pchg_pkg::ST_RD_MEM:
            begin
                cmd.rd_en  = 1'b1;
                state_next = pchg_pkg::ST_RD_DATA;
            end
            pchg_pkg::ST_RD_DATA:
            begin
                cmd.rd_take = 1'b1;
                state_next  = pchg_pkg::ST_OUT;
            end
            pchg_pkg::ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = pchg_pkg::ST_IDLE;
                end
            end
            default: state_next = pchg_pkg::ST_IDLE;
        endcase

        // The captured command is only visible in the cycle after acceptance,
        // so the dispatch happens from the first work state.
        if (state_reg == pchg_pkg::ST_IDLE && s_tvalid)
        begin
            state_next = pchg_pkg::ST_OUT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dispatch_reg <= 1'b0;
        end
        else
        begin
            dispatch_reg <= s_tready && s_tvalid;
        end
    end

    always_comb
    begin
        state_eff = state_reg;
        if (dispatch_reg)
        begin
            case (status.cmd)
                pchg_pkg::CMD_LOAD:   state_eff = pchg_pkg::ST_LOAD;
                pchg_pkg::CMD_INSERT: state_eff = pchg_pkg::ST_ROT;
                pchg_pkg::CMD_FRAME:  state_eff = pchg_pkg::ST_FE_MUL;
                pchg_pkg::CMD_READ:   state_eff = pchg_pkg::ST_RD_ADDR;
                default:              state_eff = pchg_pkg::ST_RD_ADDR;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;

`ifndef ASSERT_OFF
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten while still held");
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while one is at work");
    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        (status.sw_last && state_reg == pchg_pkg::ST_SW_RUN)
        |=> state_reg == pchg_pkg::ST_SW_DRAIN)
        else $error("grid sweep ran past its last address");
`endif

endmodule

[hw/rtl/pchg_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Height grid datapath
// Coefficient store, shared multiplier, grid memory and sweep address logic.
// ----------------------------------------------------------------------------
module pchg_datapath #(
    parameter int CELLS_X = pchg_pkg::CELLS_X_DEF,
    parameter int CELLS_Y = pchg_pkg::CELLS_Y_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [pchg_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [1:0]                        s_tuser,
    output logic [pchg_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [pchg_pkg::CFG_W-1:0]        cfg_data,
    input  pchg_pkg::ctrl_cmd_t               cmd,
    output pchg_pkg::ctrl_status_t            status
);

    localparam int NCELL = CELLS_X * CELLS_Y;
    localparam int AW    = $clog2(NCELL);
    localparam int XW    = $clog2(CELLS_X);
    localparam int YW    = $clog2(CELLS_Y);
    localparam int MAXC  = (CELLS_X > CELLS_Y) ? CELLS_X : CELLS_Y;
    localparam int AXW   = $clog2(MAXC) + 2;
    localparam int OFFW  = AW + 2;
    localparam int ACCW  = pchg_pkg::ACCW;
    localparam int BINW  = pchg_pkg::BINW;
    localparam int OPW   = pchg_pkg::OPW;
    localparam int PRW   = pchg_pkg::PRW;
    localparam int TSH   = 2 * pchg_pkg::FRAC_BITS;

    localparam logic signed [ACCW-1:0] SAT_HI = {{(ACCW-32){1'b0}}, 32'h7FFF_FFFF};
    localparam logic signed [ACCW-1:0] SAT_LO = {{(ACCW-32){1'b1}}, 32'h8000_0000};
    localparam logic signed [BINW-1:0] CX_B   = BINW'(CELLS_X);
    localparam logic signed [BINW-1:0] CY_B   = BINW'(CELLS_Y);
    localparam logic signed [AXW-1:0]  CX_A   = AXW'(CELLS_X);
    localparam logic signed [AXW-1:0]  CY_A   = AXW'(CELLS_Y);

    function automatic logic signed [31:0] sat32(input logic signed [ACCW-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < SAT_LO)
        begin
            r = -32'sh7FFF_FFFF - 32'sd1;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration and pose state (reset).
    // ------------------------------------------------------------------
    logic [pchg_pkg::CFG_W-1:0] inv_reg, half_x_reg, half_y_reg;
    logic signed [31:0]         last_x_reg, last_y_reg;
    pchg_pkg::tag_t             op_tag_reg, pr_tag_reg;
    logic                       sw_wpend_reg;

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    logic [1:0]                 cap_cmd_reg;
    logic [4:0]                 cap_cidx_reg;
    logic signed [31:0]         cap_cval_reg;
    logic [pchg_pkg::ROW_W-1:0] cap_row_reg;
    logic [pchg_pkg::COL_W-1:0] cap_col_reg;
    logic signed [31:0]         coef_reg [pchg_pkg::NUM_COEF];
    logic signed [31:0]         vec_reg [3];
    logic signed [31:0]         res_reg [3];
    logic signed [ACCW-1:0]     acc_reg;
    logic signed [OPW-1:0]      opa_reg, opb_reg;
    logic signed [PRW-1:0]      prod_reg;
    logic signed [BINW-1:0]     ix_reg, iy_reg, dx_reg, dy_reg;
    logic                       drop_reg;
    logic [AW-1:0]              ins_addr_reg;
    logic                       rd_ok_reg;
    logic [AW-1:0]              rd_addr_reg;
    logic signed [31:0]         height_reg;
    logic                       sw_axis_y_reg;
    logic signed [AXW-1:0]      dcl_reg;
    logic signed [OFFW-1:0]     off_reg;
    logic                       down_reg;
    logic [XW-1:0]              dst_x_reg;
    logic [YW-1:0]              dst_y_reg;
    logic [AW-1:0]              dst_addr_reg;
    logic [AW-1:0]              sw_waddr_reg;
    logic                       sw_wzero_reg;
    logic [pchg_pkg::OUT_DATA_W-1:0] out_reg;

    // ------------------------------------------------------------------
    // Combinational helpers.
    // ------------------------------------------------------------------
    logic signed [31:0]     coef_rd;
    logic signed [OPW-1:0]  opa_next, opb_next;
    logic signed [ACCW-1:0] fl, acc_sum;
    logic signed [BINW-1:0] tq;
    logic                   rnd;
    logic signed [ACCW-1:0] sub_diff;
    logic signed [BINW-1:0] sw_d, sw_lim;
    logic signed [AXW-1:0]  sw_dcl;
    logic signed [AXW-1:0]  coord, src_c, lim_ax;
    logic                   src_ok;
    logic signed [OFFW-1:0] src_addr;
    logic [31:0]            ram_rdata;
    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [31:0]            ram_wdata;

    assign coef_rd = coef_reg[cmd.cidx];

    always_comb
    begin
        opa_next = {coef_rd[31], coef_rd};
        opb_next = {vec_reg[cmd.vsel][31], vec_reg[cmd.vsel]};
        case (cmd.mul_sel)
            pchg_pkg::MS_BINX:
            begin
                opa_next = {vec_reg[0][31], vec_reg[0]} + {2'b00, half_x_reg};
                opb_next = {2'b00, inv_reg};
            end
            pchg_pkg::MS_BINY:
            begin
                opa_next = {vec_reg[1][31], vec_reg[1]} + {2'b00, half_y_reg};
                opb_next = {2'b00, inv_reg};
            end
            pchg_pkg::MS_FEX:
            begin
                opa_next = {coef_rd[31], coef_rd} - {last_x_reg[31], last_x_reg};
                opb_next = {2'b00, inv_reg};
            end
            pchg_pkg::MS_FEY:
            begin
                opa_next = {coef_rd[31], coef_rd} - {last_y_reg[31], last_y_reg};
                opb_next = {2'b00, inv_reg};
            end
            default:
            begin
                opa_next = {coef_rd[31], coef_rd};
                opb_next = {vec_reg[cmd.vsel][31], vec_reg[cmd.vsel]};
            end
        endcase
    end

    // Floor of a product by the fraction bits, and truncation toward zero
    // of a bin product by twice the fraction bits.
    assign fl      = ACCW'(prod_reg >>> pchg_pkg::FRAC_BITS);
    assign acc_sum = ((pr_tag_reg.kind == pchg_pkg::TK_FIRST) ? '0 : acc_reg) + fl;
    assign rnd     = prod_reg[PRW-1] && (prod_reg[TSH-1:0] != '0);
    assign tq      = BINW'(prod_reg >>> TSH) + {{(BINW-1){1'b0}}, rnd};
    assign sub_diff = ACCW'(res_reg[cmd.sub_idx]) - ACCW'(coef_rd);

    // Sweep shift distance, clamped to the grid length.
    always_comb
    begin
        case (cmd.sw_mode)
            pchg_pkg::SW_X:
            begin
                sw_d   = dx_reg;
                sw_lim = CX_B;
            end
            pchg_pkg::SW_Y:
            begin
                sw_d   = dy_reg;
                sw_lim = CY_B;
            end
            default:
            begin
                sw_d   = CX_B;
                sw_lim = CX_B;
            end
        endcase
        if (sw_d >= sw_lim)
        begin
            sw_dcl = AXW'(sw_lim);
        end
        else if (sw_d <= -sw_lim)
        begin
            sw_dcl = AXW'(-sw_lim);
        end
        else
        begin
            sw_dcl = AXW'(sw_d);
        end
    end

    assign coord    = sw_axis_y_reg ? AXW'(dst_y_reg) : AXW'(dst_x_reg);
    assign lim_ax   = sw_axis_y_reg ? CY_A : CX_A;
    assign src_c    = coord - dcl_reg;
    assign src_ok   = !src_c[AXW-1] && (src_c < lim_ax);
    assign src_addr = $signed({2'b00, dst_addr_reg}) - off_reg;

    // Memory port selection.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sw_waddr_reg;
        ram_wdata = sw_wzero_reg ? '0 : ram_rdata;
        if (sw_wpend_reg)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.ins_we && !drop_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = ins_addr_reg;
            ram_wdata = vec_reg[2];
        end
        ram_re    = 1'b0;
        ram_raddr = rd_addr_reg;
        if (cmd.sw_step)
        begin
            ram_re    = src_ok;
            ram_raddr = src_addr[AW-1:0];
        end
        else if (cmd.rd_en)
        begin
            ram_re = 1'b1;
        end
    end

    pchg_ram #(
        .WIDTH (32),
        .DEPTH (NCELL)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Control state with reset.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg      <= pchg_pkg::INV_RST;
            half_x_reg   <= pchg_pkg::HALF_X_RST;
            half_y_reg   <= pchg_pkg::HALF_Y_RST;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            op_tag_reg   <= '{kind: pchg_pkg::TK_NONE, idx: 2'd0};
            pr_tag_reg   <= '{kind: pchg_pkg::TK_NONE, idx: 2'd0};
            sw_wpend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pchg_pkg::CFG_INV:    inv_reg    <= cfg_data;
                    pchg_pkg::CFG_HALF_X: half_x_reg <= cfg_data;
                    pchg_pkg::CFG_HALF_Y: half_y_reg <= cfg_data;
                    default:              ;
                endcase
            end
            if (cmd.pose_x && status.dx_nz)
            begin
                last_x_reg <= coef_rd;
            end
            if (cmd.pose_y && status.dy_nz)
            begin
                last_y_reg <= coef_rd;
            end
            op_tag_reg   <= cmd.tag;
            pr_tag_reg   <= op_tag_reg;
            sw_wpend_reg <= cmd.sw_step;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            cap_cmd_reg  <= s_tuser;
            cap_cidx_reg <= s_tdata[4:0];
            cap_cval_reg <= s_tdata[36:5];
            vec_reg[0]   <= s_tdata[68:37];
            vec_reg[1]   <= s_tdata[100:69];
            vec_reg[2]   <= s_tdata[132:101];
            cap_row_reg  <= s_tdata[141:133];
            cap_col_reg  <= s_tdata[149:142];
        end
        else if (cmd.sub_en)
        begin
            vec_reg[cmd.sub_idx] <= sat32(sub_diff);
        end

        if (cmd.coef_we && (cap_cidx_reg < 5'(pchg_pkg::NUM_COEF)))
        begin
            coef_reg[cap_cidx_reg] <= cap_cval_reg;
        end

        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        prod_reg <= PRW'(opa_reg) * PRW'(opb_reg);

        case (pr_tag_reg.kind)
            pchg_pkg::TK_FIRST, pchg_pkg::TK_MID:
            begin
                acc_reg <= acc_sum;
            end
            pchg_pkg::TK_LAST:
            begin
                acc_reg                 <= acc_sum;
                res_reg[pr_tag_reg.idx] <= sat32(acc_sum);
            end
            pchg_pkg::TK_BINX: ix_reg <= tq;
            pchg_pkg::TK_BINY: iy_reg <= tq;
            pchg_pkg::TK_FEX:  dx_reg <= tq;
            pchg_pkg::TK_FEY:  dy_reg <= tq;
            default:           ;
        endcase

        if (cmd.bin_addr)
        begin
            drop_reg     <= ix_reg[BINW-1] || (ix_reg >= CX_B)
                         || iy_reg[BINW-1] || (iy_reg >= CY_B);
            ins_addr_reg <= AW'(AW'(ix_reg[XW-1:0]) * AW'(CELLS_Y)) + AW'(iy_reg[YW-1:0]);
        end

        if (cmd.rd_addr)
        begin
            rd_ok_reg   <= (32'(cap_row_reg) < 32'(CELLS_X))
                        && (32'(cap_col_reg) < 32'(CELLS_Y));
            rd_addr_reg <= AW'(32'(cap_row_reg) * 32'(CELLS_Y) + 32'(cap_col_reg));
        end
        if (cmd.rd_take)
        begin
            height_reg <= rd_ok_reg ? ram_rdata : '0;
        end

        // Grid sweep: the copy walks away from the side it reads, so every
        // source is read before it is overwritten.
        if (cmd.sw_init)
        begin
            sw_axis_y_reg <= (cmd.sw_mode == pchg_pkg::SW_Y);
            dcl_reg       <= sw_dcl;
        end
        if (cmd.sw_prep)
        begin
            off_reg  <= sw_axis_y_reg ? OFFW'(dcl_reg)
                                      : OFFW'(OFFW'(dcl_reg) * OFFW'(CELLS_Y));
            down_reg <= (dcl_reg > 0);
            if (dcl_reg > 0)
            begin
                dst_x_reg    <= XW'(CELLS_X - 1);
                dst_y_reg    <= YW'(CELLS_Y - 1);
                dst_addr_reg <= AW'(NCELL - 1);
            end
            else
            begin
                dst_x_reg    <= '0;
                dst_y_reg    <= '0;
                dst_addr_reg <= '0;
            end
        end
        if (cmd.sw_step)
        begin
            sw_waddr_reg <= dst_addr_reg;
            sw_wzero_reg <= !src_ok;
            if (down_reg)
            begin
                dst_addr_reg <= dst_addr_reg - AW'(1);
                if (dst_y_reg == '0)
                begin
                    dst_y_reg <= YW'(CELLS_Y - 1);
                    dst_x_reg <= dst_x_reg - XW'(1);
                end
                else
                begin
                    dst_y_reg <= dst_y_reg - YW'(1);
                end
            end
            else
            begin
                dst_addr_reg <= dst_addr_reg + AW'(1);
                if (dst_y_reg == YW'(CELLS_Y - 1))
                begin
                    dst_y_reg <= '0;
                    dst_x_reg <= dst_x_reg + XW'(1);
                end
                else
                begin
                    dst_y_reg <= dst_y_reg + YW'(1);
                end
            end
        end

        if (cmd.out_load)
        begin
            out_reg <= '0;
            case (cap_cmd_reg)
                pchg_pkg::CMD_READ:   out_reg[31:0] <= height_reg;
                pchg_pkg::CMD_INSERT: out_reg[32]   <= drop_reg;
                pchg_pkg::CMD_FRAME:
                begin
                    out_reg[42:33] <= dx_reg[pchg_pkg::SX_W-1:0];
                    out_reg[51:43] <= dy_reg[pchg_pkg::SY_W-1:0];
                end
                default: ;
            endcase
        end
    end

    assign status.cmd     = pchg_pkg::cmd_t'(cap_cmd_reg);
    assign status.dx_nz   = (dx_reg != '0);
    assign status.dy_nz   = (dy_reg != '0);
    assign status.sw_last = down_reg ? (dst_addr_reg == '0) : (dst_addr_reg == AW'(NCELL - 1));
    assign m_tdata        = out_reg;

endmodule

[test/tb_point_cloud_height_grid_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Height grid block testbench
// Loads transform coefficients, inserts camera points, shifts the grid at
// frame end and reads cells back. A scoreboard class predicts every result
// word from its own copy of the grid, coefficients and configuration, and
// compares the block's output field by field while both sides stall at random.
// ----------------------------------------------------------------------------
module tb_point_cloud_height_grid_top;
    import pchg_pkg::*;

    localparam int NX       = CELLS_X_DEF;
    localparam int NY       = CELLS_Y_DEF;
    localparam int MAX_MOVE = 6;     // frame ends that actually move the grid

    typedef struct {
        logic [31:0] height;
        logic        dropped;
        logic [9:0]  sx;
        logic [8:0]  sy;
    } grid_result_t;

    // Predicts the result word of every accepted input word and holds the
    // expectations until the block delivers them.
    class height_grid_scoreboard;
        int           grid[NX*NY];
        int           coef[NUM_COEF];
        longint       pose_x_at_shift;
        longint       pose_y_at_shift;
        longint       inv;
        longint       half_x;
        longint       half_y;
        grid_result_t pending[$];
        int           errors;
        int           inserts;
        int           drops;
        int           reads;
        int           moves;
        int           hit_row;
        int           hit_col;

        function new();
            foreach (grid[i]) grid[i] = 0;
            foreach (coef[i]) coef[i] = 0;
            pose_x_at_shift = 0;
            pose_y_at_shift = 0;
            inv = INV_RST;
            half_x = HALF_X_RST;
            half_y = HALF_Y_RST;
            errors = 0;
            inserts = 0;
            drops = 0;
            reads = 0;
            moves = 0;
            hit_row = 0;
            hit_col = 0;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Truncation toward zero of a fixed point value by s bits.
        function longint trunc_bits(longint v, int s);
            if (v < 0) return -((-v) >>> s);
            return v >>> s;
        endfunction

        // Three by three rotation; each product is floored before the row sum.
        function void rotate(int base, input longint v[3], output longint r[3]);
            longint acc;
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int j = 0; j < 3; j++)
                    acc += (longint'(coef[base + i*3 + j]) * v[j]) >>> FRAC_BITS;
                r[i] = sat32(acc);
            end
        endfunction

        function longint cells_of(longint coord, longint half);
            return trunc_bits((coord + half) * inv, 2 * FRAC_BITS);
        endfunction

        function longint pending_dx();
            return trunc_bits((longint'(coef[POSE_X]) - pose_x_at_shift) * inv, 2 * FRAC_BITS);
        endfunction

        function longint pending_dy();
            return trunc_bits((longint'(coef[POSE_Y]) - pose_y_at_shift) * inv, 2 * FRAC_BITS);
        endfunction

        function void move_rows(longint d);
            int old_grid[NX*NY];
            longint src;
            old_grid = grid;
            for (int x = 0; x < NX; x++) begin
                src = x - d;
                for (int y = 0; y < NY; y++)
                    grid[x*NY + y] = (src >= 0 && src < NX) ? old_grid[src*NY + y] : 0;
            end
        endfunction

        function void move_cols(longint d);
            int old_grid[NX*NY];
            longint src;
            old_grid = grid;
            for (int y = 0; y < NY; y++) begin
                src = y - d;
                for (int x = 0; x < NX; x++)
                    grid[x*NY + y] = (src >= 0 && src < NY) ? old_grid[x*NY + src] : 0;
            end
        endfunction

        function void config_write(logic [1:0] idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_INV:    inv = v;
                CFG_HALF_X: half_x = v;
                CFG_HALF_Y: half_y = v;
                default: ;
            endcase
        endfunction

        function void note_word(cmd_t cmd, logic [IN_DATA_W-1:0] d);
            grid_result_t res;
            longint q[3], a[3], b[3];
            longint ix, iy, dx, dy;
            int row, col;
            res = '{height: '0, dropped: 1'b0, sx: '0, sy: '0};
            case (cmd)
                CMD_LOAD: begin
                    if (d[4:0] < NUM_COEF) coef[d[4:0]] = d[36:5];
                end
                CMD_INSERT: begin
                    q[0] = longint'($signed(d[68:37]));
                    q[1] = longint'($signed(d[100:69]));
                    q[2] = longint'($signed(d[132:101]));
                    rotate(BASE_M, q, a);
                    for (int i = 0; i < 3; i++) a[i] = sat32(a[i] - coef[BASE_O + i]);
                    rotate(BASE_B, a, b);
                    for (int i = 0; i < 3; i++) b[i] = sat32(b[i] - coef[BASE_P + i]);
                    ix = cells_of(b[0], half_x);
                    iy = cells_of(b[1], half_y);
                    inserts++;
                    if (ix < 0 || ix >= NX || iy < 0 || iy >= NY) begin
                        res.dropped = 1'b1;
                        drops++;
                    end else begin
                        grid[ix*NY + iy] = int'(b[2]);
                        hit_row = int'(ix);
                        hit_col = int'(iy);
                    end
                end
                CMD_FRAME: begin
                    dx = pending_dx();
                    if (dx != 0) begin
                        move_rows(dx);
                        pose_x_at_shift = coef[POSE_X];
                    end
                    dy = pending_dy();
                    if (dy != 0) begin
                        move_cols(dy);
                        pose_y_at_shift = coef[POSE_Y];
                    end
                    if (dx != 0 || dy != 0) moves++;
                    res.sx = dx[9:0];
                    res.sy = dy[8:0];
                end
                default: begin
                    row = int'(d[141:133]);
                    col = int'(d[149:142]);
                    reads++;
                    if (row < NX && col < NY) res.height = grid[row*NY + col];
                end
            endcase
            pending.push_back(res);
        endfunction

        function void check_word(logic [OUT_DATA_W-1:0] w);
            grid_result_t exp_res;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word %h", $realtime, w);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (w[31:0] !== exp_res.height) begin
                $display("%0t: cell_height expected %h actual %h",
                         $realtime, exp_res.height, w[31:0]);
                errors++;
            end
            if (w[32] !== exp_res.dropped) begin
                $display("%0t: point_dropped expected %b actual %b",
                         $realtime, exp_res.dropped, w[32]);
                errors++;
            end
            if (w[42:33] !== exp_res.sx) begin
                $display("%0t: shift_x_cells expected %0d actual %0d",
                         $realtime, $signed(exp_res.sx), $signed(w[42:33]));
                errors++;
            end
            if (w[51:43] !== exp_res.sy) begin
                $display("%0t: shift_y_cells expected %0d actual %0d",
                         $realtime, $signed(exp_res.sy), $signed(w[51:43]));
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we;
    logic [1:0]             cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    height_grid_scoreboard sb = new();
    bit calm = 1'b0;   // when set, neither side idles

    point_cloud_height_grid_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // The receiving side stalls about a third of the time unless the calm
    // stretch is running. Outputs are sampled before this edge's updates land.
    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= 36);
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata);
    end

    // Sends one word; valid stays high into the next word unless a gap is drawn.
    task automatic send_word(cmd_t cmd, logic [4:0] idx, logic [31:0] value,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [8:0] row, logic [7:0] col);
        logic [IN_DATA_W-1:0] d;
        d = {2'b00, col, row, pz, py, px, value, idx};
        if (!calm && $urandom_range(0, 99) < 36) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= cmd;
        do @(posedge clk); while (!s_tready);
        sb.note_word(cmd, d);
    endtask

    task automatic load_coef(logic [4:0] idx, logic [31:0] value);
        send_word(CMD_LOAD, idx, value, $urandom, $urandom, $urandom,
                  9'($urandom), 8'($urandom));
    endtask

    task automatic insert_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        send_word(CMD_INSERT, 5'($urandom), $urandom, px, py, pz,
                  9'($urandom), 8'($urandom));
    endtask

    task automatic read_cell(logic [8:0] row, logic [7:0] col);
        send_word(CMD_READ, 5'($urandom), $urandom, $urandom, $urandom, $urandom, row, col);
    endtask

    task automatic end_frame();
        send_word(CMD_FRAME, 5'($urandom), $urandom, $urandom, $urandom, $urandom,
                  9'($urandom), 8'($urandom));
    endtask

    // Lets every expected word arrive, then a few more cycles of quiet.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.config_write(idx, v);
    endtask

    function automatic logic [31:0] small_val(int span);
        return $urandom_range(0, 2*span) - span;
    endfunction

    // A plausible value for a coefficient slot: near-identity rotations,
    // modest offsets and a pose that stays within a few cells.
    function automatic logic [31:0] sane_coef(int idx);
        if (idx < 9 || (idx >= 12 && idx < 21))
            return ((idx % 12) % 4 == 0) ? 32'd65536 + small_val(2000) : small_val(3000);
        if (idx < 12) return small_val(20000);
        if (idx == POSE_X || idx == POSE_Y) return small_val(3000);
        return small_val(20000);
    endfunction

    task automatic load_sane_set();
        for (int i = 0; i < NUM_COEF; i++) load_coef(5'(i), sane_coef(i));
    endtask

    task automatic random_phase(int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                r = $urandom_range(0, NUM_COEF - 1);
                load_coef(5'(r), sane_coef(r));
            end else if (r < 11) begin
                // Noise: any slot value, indexes above the store included.
                load_coef(5'($urandom_range(0, 31)), $urandom);
            end else if (r < 60) begin
                if ($urandom_range(0, 9) == 0)
                    insert_point($urandom, $urandom, $urandom);
                else
                    insert_point(small_val(60000), small_val(60000), small_val(200000));
            end else if (r < 65 && (sb.moves < MAX_MOVE ||
                                    (sb.pending_dx() == 0 && sb.pending_dy() == 0))) begin
                // Frame ends that would move the grid are rationed, since each
                // moving axis costs a full sweep of the grid.
                end_frame();
            end else if ($urandom_range(0, 1) == 0) begin
                read_cell(9'(sb.hit_row), 8'(sb.hit_col));
            end else begin
                read_cell(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_LOAD;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_INV;
        cfg_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset configuration: identity rotations, no
        // offsets and the pose at the origin, so the centre cell is known.
        for (int i = 0; i < NUM_COEF; i++)
            load_coef(5'(i), (i == 0 || i == 4 || i == 8 || i == 12 || i == 16 || i == 20)
                             ? 32'd65536 : 32'd0);
        load_coef(5'd31, 32'hFFFF_FFFF);               // beyond the store, ignored
        insert_point(32'd0, 32'd0, 32'd12345);         // lands in cell (150, 100)
        read_cell(9'd150, 8'd100);
        insert_point(-32'sd49153, 32'd0, 32'h7FFF_FFFF); // just below the edge: cell 0
        insert_point(-32'sd49153 - 32'sd327, 32'd0, 32'd1); // well below: dropped
        insert_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000); // saturates
        read_cell(9'd0, 8'd100);
        read_cell(9'd299, 8'd199);
        read_cell(9'd511, 8'd255);                     // outside the grid, reads zero
        end_frame();                                   // no pose change, no shift
        load_coef(POSE_X, 32'd700);
        end_frame();                                   // two cells along x
        read_cell(9'd152, 8'd100);
        load_coef(POSE_Y, -32'sd400);
        end_frame();                                   // one cell back along y
        read_cell(9'd152, 8'd99);
        wait_idle();

        // Random phases over several configurations, extremes included.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1: begin
                    write_reg(CFG_INV, 31'h7FFF_FFFF);
                    write_reg(CFG_HALF_X, 31'd0);
                    write_reg(CFG_HALF_Y, 31'd0);
                end
                2: begin
                    write_reg(CFG_INV, 31'd1);
                    write_reg(CFG_HALF_X, 31'h7FFF_FFFF);
                    write_reg(CFG_HALF_Y, 31'h7FFF_FFFF);
                end
                3: write_reg(CFG_INV, 31'd0);          // every point bins to cell 0
                4: begin
                    write_reg(CFG_INV, 31'd6553600);
                    write_reg(CFG_HALF_X, 31'd98304);
                    write_reg(CFG_HALF_Y, 31'd65536);
                end
                5: begin
                    write_reg(CFG_INV, INV_RST);
                    write_reg(CFG_HALF_X, HALF_X_RST);
                    write_reg(CFG_HALF_Y, HALF_Y_RST);
                    write_reg(2'd3, 31'h5555_5555);    // no such register
                end
                default: ;
            endcase
            if (phase == 2) calm = 1'b1;
            load_sane_set();
            random_phase(240);
            calm = 1'b0;
            wait_idle();
        end

        $display("Covered %0d inserts (%0d dropped), %0d reads and %0d grid moves",
                 sb.inserts, sb.drops, sb.reads, sb.moves);
        $display("across six configurations including the register extremes.");
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("Timeout with %0d words outstanding", sb.pending.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
